/* design/memory_test_pattern_fill_verify_defines.svh */
// ---------------------------------------------------------------------------
// Memory test pattern fill/verify: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef MEMORY_TEST_PATTERN_FILL_VERIFY_DEFINES_SVH
`define MEMORY_TEST_PATTERN_FILL_VERIFY_DEFINES_SVH

// same-cycle implication
`define MTPFV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTPFV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mtpfv_pkg.sv */
// ---------------------------------------------------------------------------
// Memory test pattern fill/verify: package
// Widths, register indexes, pattern codes, seed constants and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package mtpfv_pkg;

  localparam int WORD_W    = 32;
  localparam int IDX_W     = 31;
  localparam int CNT_W     = 8;
  localparam int KIND_W    = 2;
  localparam int REG_IDX_W = 3;

  localparam int OUT_FIELDS_W = 2 * WORD_W + 1 + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE  = 3'd0,
    REG_COUNT = 3'd1,
    REG_KIND  = 3'd2,
    REG_MODE  = 3'd3,
    REG_LIMIT = 3'd4
  } reg_index_t;

  localparam logic [KIND_W-1:0] KIND_ZERO   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INCR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BASE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RANDOM = 2'd3;

  localparam logic [WORD_W-1:0] SEED_MUL_A = 32'hdeadbeef;
  localparam logic [WORD_W-1:0] SEED_MUL_B = 32'hcaf76451;
  localparam int TAP_HIGH_BIT = 31;
  localparam int TAP_MID_BIT  = 27;

  localparam logic [WORD_W-1:0] RST_BASE  = 32'd0;
  localparam logic [IDX_W-1:0]  RST_COUNT = 31'd1;
  localparam logic [KIND_W-1:0] RST_KIND  = KIND_ZERO;
  localparam logic              RST_MODE  = 1'b0;
  localparam logic [CNT_W-1:0]  RST_LIMIT = 8'd10;
  localparam logic [CNT_W-1:0]  CNT_MAX   = 8'hff;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [CNT_W-1:0]  mismatch_total;
    logic              mismatch;
    logic [WORD_W-1:0] pattern_word;
    logic [WORD_W-1:0] word_address;
  } result_t;

endpackage

`default_nettype wire

/* design/mtpfv_fifo.sv */
// ---------------------------------------------------------------------------
// Memory test pattern fill/verify: read word queue
// Short queue of read words between the front stage and the engine.
// ---------------------------------------------------------------------------
`default_nettype none

module mtpfv_fifo
  import mtpfv_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [WORD_W-1:0] push_data,
  input  wire logic              pop,
  output logic      [WORD_W-1:0] pop_data,
  output q_status_t              stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/mtpfv_front.sv */
// ---------------------------------------------------------------------------
// Memory test pattern fill/verify: front stage
// Accept read words from the input stream and hand them to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module mtpfv_front
  import mtpfv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [WORD_W-1:0] s_tdata,
  input  wire q_status_t         q_stat,
  output logic                   push,
  output logic      [WORD_W-1:0] push_data
);

  logic              hold_valid;
  logic              hold_valid_next;
  logic [WORD_W-1:0] hold_word;
  logic              accept;

  assign push            = hold_valid && !q_stat.full;
  assign push_data       = hold_word;
  assign s_tready        = !hold_valid || push;
  assign accept          = s_tvalid && s_tready;
  assign hold_valid_next = (hold_valid && !push) || accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_word <= s_tdata;
    end
  end

endmodule

`default_nettype wire

/* design/mtpfv_back.sv */
// ---------------------------------------------------------------------------
// Memory test pattern fill/verify: engine
// Hold configuration, seed and step the pattern generators, compare, count
// mismatches and drive the registered result.
// ---------------------------------------------------------------------------
`default_nettype none

module mtpfv_back
  import mtpfv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  input  wire q_status_t            q_stat,
  input  wire logic [WORD_W-1:0]    read_word,
  output logic                      pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output result_t                   result,
  output logic                      pass_end
);

  logic [WORD_W-1:0] base;
  logic [IDX_W-1:0]  count;
  logic [KIND_W-1:0] kind;
  logic              mode;
  logic [CNT_W-1:0]  limit;
  logic              reseed;
  logic              cfg_hit;

  logic [WORD_W-1:0] seed_a;
  logic [WORD_W-1:0] seed_b;
  logic [WORD_W-1:0] seed_a_next;
  logic [WORD_W-1:0] seed_b_next;
  logic [WORD_W-1:0] prod_a;

  logic [WORD_W-1:0] gen_a;
  logic [WORD_W-1:0] gen_b;
  logic [WORD_W-1:0] gen_a_next;
  logic [WORD_W-1:0] gen_b_next;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;

  logic [WORD_W-1:0] addr;
  logic [WORD_W-1:0] pattern;
  logic [WORD_W-1:0] rnd_a;
  logic [WORD_W-1:0] rnd_b;
  logic [WORD_W-1:0] idx_inc;
  logic              mis;
  logic              end_now;

  always_comb begin
    case (reg_index_t'(cfg_index))
      REG_BASE, REG_COUNT, REG_KIND, REG_MODE, REG_LIMIT: cfg_hit = cfg_write;
      default: cfg_hit = 1'b0;
    endcase
  end

  assign prod_a      = base * SEED_MUL_A;
  assign seed_b_next = base * SEED_MUL_B;

  always_comb begin
    case (kind)
      KIND_BASE:   seed_a_next = base;
      KIND_RANDOM: seed_a_next = prod_a + {1'b0, count};
      default:     seed_a_next = '0;
    endcase
  end

  assign rnd_a = {gen_a[WORD_W-2:0], 1'b0}
               ^ {{(WORD_W-1){1'b0}}, ~gen_a[TAP_HIGH_BIT]}
               ^ {{(WORD_W-1){1'b0}}, ~gen_a[TAP_MID_BIT]};
  assign rnd_b = {gen_b[18:0], gen_b[31:19]}
               ^ {{(WORD_W-1){1'b0}}, ~gen_b[TAP_HIGH_BIT]}
               ^ {{(WORD_W-1){1'b0}}, ~gen_b[TAP_MID_BIT]};

  always_comb begin
    gen_a_next = gen_a;
    gen_b_next = gen_b;
    case (kind)
      KIND_INCR, KIND_BASE: begin
        pattern    = gen_a;
        gen_a_next = gen_a + WORD_W'(1);
      end
      KIND_RANDOM: begin
        pattern    = rnd_a ^ rnd_b;
        gen_a_next = rnd_a;
        gen_b_next = rnd_b;
      end
      default: pattern = '0;
    endcase
  end

  assign addr     = base + {idx[WORD_W-3:0], 2'b00};
  assign mis      = mode && (read_word != pattern);
  assign cnt_next = (mis && (cnt != CNT_MAX)) ? cnt + CNT_W'(1) : cnt;
  assign idx_inc  = {1'b0, idx} + WORD_W'(1);
  assign end_now  = (idx_inc >= {1'b0, count})
                 || (mis && (limit != '0) && (cnt_next >= limit));

  assign pop = !q_stat.empty && !reseed && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= RST_BASE;
      count  <= RST_COUNT;
      kind   <= RST_KIND;
      mode   <= RST_MODE;
      limit  <= RST_LIMIT;
      reseed <= 1'b1;
      idx    <= '0;
      cnt    <= '0;
    end else begin
      if (reseed) begin
        idx    <= '0;
        cnt    <= '0;
        reseed <= 1'b0;
      end else if (pop) begin
        idx <= end_now ? '0 : idx_inc[IDX_W-1:0];
        cnt <= end_now ? '0 : cnt_next;
      end
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_BASE:  base  <= cfg_data;
          REG_COUNT: count <= cfg_data[IDX_W-1:0];
          REG_KIND:  kind  <= cfg_data[KIND_W-1:0];
          REG_MODE:  mode  <= cfg_data[0];
          REG_LIMIT: limit <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        reseed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (reseed) begin
      seed_a <= seed_a_next;
      seed_b <= seed_b_next;
      gen_a  <= seed_a_next;
      gen_b  <= seed_b_next;
    end else if (pop) begin
      gen_a <= end_now ? seed_a : gen_a_next;
      gen_b <= end_now ? seed_b : gen_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.word_address   <= addr;
      result.pattern_word   <= pattern;
      result.mismatch       <= mis;
      result.mismatch_total <= cnt_next;
      pass_end              <= end_now;
    end
  end

endmodule

`default_nettype wire

/* design/memory_test_pattern_fill_verify.sv */
// ---------------------------------------------------------------------------
// Memory test pattern fill/verify
// Fill or verify one region of 32-bit words with a zero, counting, address
// or pseudo-random pattern; one result per read word.
// ---------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid/s_tready    read word
//   m_*      out        m_tvalid/m_tready    address, pattern, mismatch, total
//   cfg_*    in         cfg_write            register index, write data
//
// One word per clock unless the output stalls or the engine is seeding; the
// engine loop (generator step, compare, mismatch count, pass end) is
// combinational. Input words pass through the front stage, the queue and the
// output register. After reset or a write to a defined register the engine
// seeds the generators. Either side may stall independently.
// ---------------------------------------------------------------------------
`default_nettype none

module memory_test_pattern_fill_verify
  import mtpfv_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [WORD_W-1:0]      s_tdata,   // read_word
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata,   // word_address, pattern_word,
                                                 // mismatch, mismatch_total
  output logic                        m_tlast,   // pass_end
  input  wire logic                   cfg_write,
  input  wire logic [REG_IDX_W-1:0]   cfg_index,
  input  wire logic [WORD_W-1:0]      cfg_data
);

`include "memory_test_pattern_fill_verify_defines.svh"

  q_status_t         q_stat;
  logic              push;
  logic [WORD_W-1:0] push_data;
  logic              pop;
  logic [WORD_W-1:0] pop_data;
  result_t           result;

  mtpfv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  mtpfv_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  mtpfv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .read_word (pop_data),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .result    (result),
    .pass_end  (m_tlast)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, result};

  `MTPFV_ASSERT_IMP(a_no_overflow, clk, rst, push, !q_stat.full, "queue push while full")
  `MTPFV_ASSERT_IMP(a_no_underflow, clk, rst, pop, !q_stat.empty, "queue pop while empty")
  `MTPFV_ASSERT_IMP(a_mis_counted, clk, rst, m_tvalid && result.mismatch, result.mismatch_total != '0, "mismatch with zero total")
  `MTPFV_ASSERT_NXT(a_pop_shows, clk, rst, pop, m_tvalid, "engine result not presented")

endmodule

`default_nettype wire

/* sim/memory_test_pattern_fill_verify_tb.sv */
// ---------------------------------------------------------------------------
// Memory test pattern fill/verify: testbench
// Streams read words into the engine under a series of register settings,
// predicts address, pattern word, mismatch flag, running total and pass end
// for every transaction, and checks each result in order as it leaves.
// ---------------------------------------------------------------------------
module memory_test_pattern_fill_verify_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtpfv_pkg::*;

  localparam int LATENCY     = 3;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int WORD_TARGET = 1100;

  typedef struct {
    logic [WORD_W-1:0] word_address;
    logic [WORD_W-1:0] pattern_word;
    logic              mismatch;
    logic [CNT_W-1:0]  mismatch_total;
    logic              pass_end;
  } word_result_t;

  class pattern_scoreboard;
    logic [WORD_W-1:0] base_address;
    logic [IDX_W-1:0]  word_count;
    logic [KIND_W-1:0] pattern_kind;
    logic              check_mode;
    logic [CNT_W-1:0]  report_limit;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] gen_a;
    logic [WORD_W-1:0] gen_b;
    logic [CNT_W-1:0]  miss_count;
    word_result_t      expected_q[$];
    int                failures;
    int                passes;
    int                flagged;

    function new();
      base_address = RST_BASE;
      word_count   = RST_COUNT;
      pattern_kind = RST_KIND;
      check_mode   = RST_MODE;
      report_limit = RST_LIMIT;
      failures     = 0;
      passes       = 0;
      flagged      = 0;
      reseed();
    endfunction

    function void reseed();
      word_index = '0;
      miss_count = '0;
      gen_b      = base_address * SEED_MUL_B;
      case (pattern_kind)
        KIND_BASE:   gen_a = base_address;
        KIND_RANDOM: gen_a = base_address * SEED_MUL_A + WORD_W'(word_count);
        default:     gen_a = '0;
      endcase
    endfunction

    function void write_register(logic [REG_IDX_W-1:0] index, logic [WORD_W-1:0] value);
      case (index)
        REG_BASE:  base_address = value;
        REG_COUNT: word_count   = value[IDX_W-1:0];
        REG_KIND:  pattern_kind = value[KIND_W-1:0];
        REG_MODE:  check_mode   = value[0];
        REG_LIMIT: report_limit = value[CNT_W-1:0];
        default:   return;
      endcase
      reseed();
    endfunction

    function logic [WORD_W-1:0] step_generators(inout logic [WORD_W-1:0] a,
                                                inout logic [WORD_W-1:0] b);
      logic [WORD_W-1:0] na;
      logic [WORD_W-1:0] nb;
      logic [WORD_W-1:0] taps_a;
      logic [WORD_W-1:0] taps_b;
      taps_a = {{(WORD_W-1){1'b0}}, ~a[TAP_HIGH_BIT]} ^ {{(WORD_W-1){1'b0}}, ~a[TAP_MID_BIT]};
      taps_b = {{(WORD_W-1){1'b0}}, ~b[TAP_HIGH_BIT]} ^ {{(WORD_W-1){1'b0}}, ~b[TAP_MID_BIT]};
      case (pattern_kind)
        KIND_INCR, KIND_BASE: begin
          na = a;
          a  = a + 1;
          return na;
        end
        KIND_RANDOM: begin
          na = (a << 1) ^ taps_a;
          nb = (b << 13) ^ (b >> 19) ^ taps_b;
          a  = na;
          b  = nb;
          return na ^ nb;
        end
        default: return '0;
      endcase
    endfunction

    function logic [WORD_W-1:0] upcoming_pattern();
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      a = gen_a;
      b = gen_b;
      return step_generators(a, b);
    endfunction

    function void note_read(logic [WORD_W-1:0] read_word);
      word_result_t r;
      logic         at_end;
      r.word_address = base_address + (WORD_W'(word_index) << 2);
      r.pattern_word = step_generators(gen_a, gen_b);
      r.mismatch     = check_mode && (read_word != r.pattern_word);
      if (r.mismatch) begin
        flagged++;
        if (miss_count != CNT_MAX) miss_count++;
      end
      at_end = (WORD_W'(word_index) + 1) >= WORD_W'(word_count);
      if (r.mismatch && report_limit != 0 && miss_count >= report_limit) at_end = 1'b1;
      r.mismatch_total = miss_count;
      r.pass_end       = at_end;
      expected_q.push_back(r);
      if (at_end) begin
        passes++;
        reseed();
      end else begin
        word_index++;
      end
    endfunction

    function void check_result(result_t got, logic got_end);
      word_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected transaction: addr %h pattern %h miss %b total %0d end %b",
                   got.word_address, got.pattern_word, got.mismatch, got.mismatch_total,
                   got_end);
        return;
      end
      want = expected_q.pop_front();
      if (got.word_address !== want.word_address || got.pattern_word !== want.pattern_word ||
          got.mismatch !== want.mismatch || got.mismatch_total !== want.mismatch_total ||
          got_end !== want.pass_end) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("wrong result: expected addr %h pattern %h miss %b total %0d end %b",
                   want.word_address, want.pattern_word, want.mismatch,
                   want.mismatch_total, want.pass_end);
          $display("              got      addr %h pattern %h miss %b total %0d end %b",
                   got.word_address, got.pattern_word, got.mismatch, got.mismatch_total,
                   got_end);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [WORD_W-1:0]       s_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    m_tlast;
  logic                    cfg_write;
  logic [REG_IDX_W-1:0]    cfg_index;
  logic [WORD_W-1:0]       cfg_data;

  pattern_scoreboard sb;
  bit                stall_on;
  int                words_sent;
  int                setups;
  int                idle_cycles;

  memory_test_pattern_fill_verify i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    wait (sb != null && !rst);
    @(negedge clk);
    forever begin
      stall = stall_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(result_t'(m_tdata[OUT_FIELDS_W-1:0]), m_tlast);
      @(negedge clk);
    end
  end

  task automatic settle();
    while (sb.pending() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_register(logic [REG_IDX_W-1:0] index, logic [WORD_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    sb.write_register(index, value);
  endtask

  task automatic finish_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(logic [WORD_W-1:0] base, logic [WORD_W-1:0] count,
                           logic [WORD_W-1:0] kind, logic [WORD_W-1:0] mode,
                           logic [WORD_W-1:0] limit);
    settle();
    write_register(REG_BASE, base);
    write_register(REG_COUNT, count);
    write_register(REG_KIND, kind);
    write_register(REG_MODE, mode);
    write_register(REG_LIMIT, limit);
    finish_writes();
    setups++;
  endtask

  task automatic run_words(int n_words, int error_pct, bit idle_on, int pause_at);
    logic [WORD_W-1:0] rw;
    int                gap;
    for (int i = 0; i < n_words; i++) begin
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (i == pause_at && gap == 0) gap = 1;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
        if (i == pause_at) while (sb.pending() != 0) @(negedge clk);
      end
      rw = sb.upcoming_pattern();
      if (!sb.check_mode) begin
        rw = $urandom;
      end else if ($urandom_range(0, 99) < error_pct) begin
        case ($urandom_range(0, 2))
          0:       rw = ~rw;
          1:       rw = rw ^ (32'd1 << $urandom_range(0, WORD_W - 1));
          default: rw = $urandom;
        endcase
      end
      s_tvalid <= 1'b1;
      s_tdata  <= rw;
      do @(posedge clk); while (!s_tready);
      sb.note_read(rw);
      words_sent++;
      @(negedge clk);
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin : stimulus
    int          n_words;
    int          error_pct;
    int          pause_at;
    bit          first_random;
    logic [31:0] count;
    logic [31:0] limit;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_write  = 1'b0;
    cfg_index  = REG_BASE;
    cfg_data   = '0;
    stall_on   = 1'b1;
    words_sent = 0;
    setups     = 0;
    idle_cycles = 0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: single-word passes of zeros
    run_words(2, 0, 1, -1);

    // address pattern wrapping past the top of the address space
    configure(32'hffff_fff8, 4, KIND_BASE, 0, 10);
    run_words(2, 0, 0, -1);
    settle();
    // undefined register indexes leave the running pass alone
    for (int i = REG_LIMIT + 1; i < 2 ** REG_IDX_W; i++)
      write_register(REG_IDX_W'(i), $urandom);
    finish_writes();
    run_words(2, 0, 1, -1);

    // smallest report limit ends the pass on the first mismatch
    configure(32'h0000_1000, 3, KIND_INCR, 1, 1);
    run_words(2, 100, 1, -1);

    // zero word count after masking, random pattern, largest limit
    configure(32'h1234_5678, 32'h8000_0000, KIND_RANDOM, 1, CNT_MAX);
    run_words(3, 50, 0, -1);

    // zero pattern against corrupted reads, early stop at two
    configure(32'hffff_ffff, 32'h7fff_ffff, KIND_ZERO, 1, 2);
    run_words(3, 100, 1, -1);

    // upper register bits ignored; zero limit
    configure(32'h0000_0000, 2, 32'hffff_fffc, 32'hffff_fffe, 32'hffff_ff00);
    run_words(2, 0, 1, -1);

    // long verify pass with no limit: counter saturates
    configure($urandom, 300, KIND_RANDOM, 1, 0);
    run_words(300, 100, 1, -1);

    first_random = 1'b1;
    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 9))
        0:       count = $urandom;
        1:       count = 0;
        default: count = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 5))
        0:       limit = 0;
        1:       limit = CNT_MAX;
        default: limit = $urandom_range(1, 20);
      endcase
      limit = ($urandom & 32'hffff_ff00) | limit;
      case ($urandom_range(0, 3))
        0:       error_pct = 0;
        1:       error_pct = 3;
        2:       error_pct = 15;
        default: error_pct = 60;
      endcase
      n_words  = $urandom_range(20, 70);
      pause_at = first_random ? n_words / 2 : -1;
      stall_on = $urandom_range(0, 3) != 0;
      configure($urandom, count, $urandom, $urandom, limit);
      run_words(n_words, error_pct, $urandom_range(0, 3) != 0, pause_at);
      first_random = 1'b0;
    end

    stall_on = 1'b1;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);

    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    $display("Covered %0d words under %0d register setups, %0d passes ended,",
             words_sent, setups, sb.passes);
    $display("%0d mismatches flagged, %0d result errors", sb.flagged, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
